// File: sv/csc_pkg.sv
package csc_pkg;

    // The radius field has a fixed width, independent of the coordinate width.
    localparam int RADIUS_WIDTH = 15;
    localparam int RR_WIDTH     = 2 * RADIUS_WIDTH;

    // Load enables for the two register ranks of a split multiplier.
    typedef struct packed {
        logic pp;
        logic sum;
    } mul_en_t;

endpackage

// File: sv/csc_split_mul.sv
module csc_split_mul #(
    parameter int AW = 34,
    parameter int BW = 34
) (
    input  logic                 clk,
    input  csc_pkg::mul_en_t     en,
    input  logic [AW-1:0]        a,
    input  logic [BW-1:0]        b,
    output logic [AW+BW-1:0]     p
);
    import csc_pkg::*;

    localparam int AL = (AW + 1) / 2;
    localparam int AH = AW - AL;
    localparam int BL = (BW + 1) / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic [AL+BL-1:0] ll_reg;
    logic [AL+BH-1:0] lh_reg;
    logic [AH+BL-1:0] hl_reg;
    logic [AH+BH-1:0] hh_reg;
    logic [PW-1:0]    p_reg;
    logic [PW-1:0]    p_next;

    // First rank: four half-width partial products.
    always_ff @(posedge clk)
    begin
        if (en.pp)
        begin
            ll_reg <= a[AL-1:0]  * b[BL-1:0];
            lh_reg <= a[AL-1:0]  * b[BW-1:BL];
            hl_reg <= a[AW-1:AL] * b[BL-1:0];
            hh_reg <= a[AW-1:AL] * b[BW-1:BL];
        end
    end

    // Second rank: shift the partial products into place and add them.
    always_comb
    begin
        p_next = (PW'(hh_reg) << (AL + BL))
               + (PW'(lh_reg) << BL)
               + (PW'(hl_reg) << AL)
               + PW'(ll_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en.sum)
        begin
            p_reg <= p_next;
        end
    end

    assign p = p_reg;

endmodule

// File: sv/circle_segment_collision_test.sv
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------------
// input    | in_valid, in_stall  | wall_x1, wall_y1, wall_x2, wall_y2, ball_x,
//          |                     | ball_y, ball_radius
// output   | out_valid, out_stall| hit
//
// One item is taken every cycle while in_stall is low; each result passes through
// the six register ranks: differences, products, sums, partial products,
// partial-product sums and the final compare.
// Reset clears only the valid bits of the six ranks; the data registers are not reset.
// A stall on the output holds the last rank, and each rank further up holds only
// when the rank below it is full and held, so empty slots are filled while stalled.
module circle_segment_collision_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_WIDTH-1:0]     wall_x1,
    input  logic signed [COORD_WIDTH-1:0]     wall_y1,
    input  logic signed [COORD_WIDTH-1:0]     wall_x2,
    input  logic signed [COORD_WIDTH-1:0]     wall_y2,
    input  logic signed [COORD_WIDTH-1:0]     ball_x,
    input  logic signed [COORD_WIDTH-1:0]     ball_y,
    input  logic [csc_pkg::RADIUS_WIDTH-1:0]  ball_radius,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              hit
);
    import csc_pkg::*;

    localparam int DW   = COORD_WIDTH + 1;
    localparam int PRW  = 2 * DW;
    localparam int LW   = PRW + 1;
    localparam int CW   = PRW;
    localparam int EW   = (LW > RR_WIDTH) ? LW : RR_WIDTH;
    localparam int X2W  = 2 * CW;
    localparam int LMW  = LW + RR_WIDTH;
    localparam int CMPW = (X2W > LMW) ? X2W : LMW;

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    // Stage 1: coordinate differences.
    logic signed [DW-1:0] dx1_reg, dy1_reg, dx2_reg, dy2_reg, ex_reg, ey_reg;
    logic [RADIUS_WIDTH-1:0] r1_reg;

    // Stage 2: products.
    logic signed [PRW-1:0] sx1_reg, sy1_reg, sx2_reg, sy2_reg, sex_reg, sey_reg;
    logic signed [PRW-1:0] cp_reg, cq_reg, dp_reg, dq_reg;
    logic [RR_WIDTH-1:0]   rr2_reg;

    // Stage 3: sums and the endpoint test.
    logic [LW-1:0]         d1_next, d2_next, len2_next, len2_reg;
    logic signed [LW-1:0]  cross_next, dot_next, dot_reg;
    logic [CW-1:0]         cross_abs_next, cross_abs_reg;
    logic                  endp_next, endp3_reg;
    logic [RR_WIDTH-1:0]   rr3_reg;

    // Stages 4 and 5: projection test carried beside the split multipliers.
    logic                  dot_ok_next, dot_ok4_reg, dot_ok5_reg, endp4_reg, endp5_reg;
    logic [X2W-1:0]        cross2;
    logic [LMW-1:0]        lim;
    mul_en_t               mul_en;

    // Stage 6: result.
    logic                  hit_reg, hit_next;

    assign en6 = !v6_reg || !out_stall;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign in_stall  = !en1;
    assign out_valid = v6_reg;
    assign hit       = hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
            if (en6) v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            dx1_reg <= DW'(ball_x)  - DW'(wall_x1);
            dy1_reg <= DW'(ball_y)  - DW'(wall_y1);
            dx2_reg <= DW'(ball_x)  - DW'(wall_x2);
            dy2_reg <= DW'(ball_y)  - DW'(wall_y2);
            ex_reg  <= DW'(wall_x2) - DW'(wall_x1);
            ey_reg  <= DW'(wall_y2) - DW'(wall_y1);
            r1_reg  <= ball_radius;
        end
    end

    // The cross product of (centre to first end) and (centre to second end)
    // equals dx1 * dy2 - dy1 * dx2 in the differences taken from the centre.
    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            sx1_reg <= dx1_reg * dx1_reg;
            sy1_reg <= dy1_reg * dy1_reg;
            sx2_reg <= dx2_reg * dx2_reg;
            sy2_reg <= dy2_reg * dy2_reg;
            sex_reg <= ex_reg * ex_reg;
            sey_reg <= ey_reg * ey_reg;
            cp_reg  <= dx1_reg * dy2_reg;
            cq_reg  <= dy1_reg * dx2_reg;
            dp_reg  <= dx1_reg * ex_reg;
            dq_reg  <= dy1_reg * ey_reg;
            rr2_reg <= r1_reg * r1_reg;
        end
    end

    always_comb
    begin
        d1_next    = {1'b0, sx1_reg} + {1'b0, sy1_reg};
        d2_next    = {1'b0, sx2_reg} + {1'b0, sy2_reg};
        len2_next  = {1'b0, sex_reg} + {1'b0, sey_reg};
        cross_next = LW'(cp_reg) - LW'(cq_reg);
        dot_next   = LW'(dp_reg) + LW'(dq_reg);
        cross_abs_next = cross_next[LW-1] ? CW'(-cross_next) : CW'(cross_next);
        endp_next  = (EW'(d1_next) < EW'(rr2_reg)) || (EW'(d2_next) < EW'(rr2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            len2_reg      <= len2_next;
            dot_reg       <= dot_next;
            cross_abs_reg <= cross_abs_next;
            endp3_reg     <= endp_next;
            rr3_reg       <= rr2_reg;
        end
    end

    assign mul_en.pp  = en4;
    assign mul_en.sum = en5;

    csc_split_mul #(
        .AW (CW),
        .BW (CW)
    ) u_cross_sq (
        .clk (clk),
        .en  (mul_en),
        .a   (cross_abs_reg),
        .b   (cross_abs_reg),
        .p   (cross2)
    );

    csc_split_mul #(
        .AW (LW),
        .BW (RR_WIDTH)
    ) u_limit (
        .clk (clk),
        .en  (mul_en),
        .a   (len2_reg),
        .b   (rr3_reg),
        .p   (lim)
    );

    // The centre projects onto the segment, ends included, when 0 <= dot <= len^2.
    assign dot_ok_next = !dot_reg[LW-1] && ({1'b0, dot_reg[LW-2:0]} <= len2_reg);

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            dot_ok4_reg <= dot_ok_next;
            endp4_reg   <= endp3_reg;
        end
        if (en5)
        begin
            dot_ok5_reg <= dot_ok4_reg;
            endp5_reg   <= endp4_reg;
        end
    end

    assign hit_next = endp5_reg || (dot_ok5_reg && (CMPW'(cross2) < CMPW'(lim)));

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            hit_reg <= hit_next;
        end
    end

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted item did not enter the first rank");

    a_rank_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && en6) |=> v6_reg)
        else $error("item lost between the last two ranks");

    a_endpoint_hits: assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && en6 && endp5_reg) |=> hit_reg)
        else $error("endpoint inside the circle did not give a hit");

    a_zero_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && (rr3_reg == '0)) |-> !endp3_reg)
        else $error("endpoint test fired with zero radius");

endmodule

// File: verif/circle_segment_collision_test_test.sv
`timescale 1ns / 1ps

module circle_segment_collision_test_test;

    localparam int COORD_WIDTH   = 16;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int SETTLE_CYCLES = 20;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [csc_pkg::RADIUS_WIDTH-1:0] radius_t;

    typedef struct packed {
        coord_t  wall_x1;
        coord_t  wall_y1;
        coord_t  wall_x2;
        coord_t  wall_y2;
        coord_t  ball_x;
        coord_t  ball_y;
        radius_t ball_radius;
    } wall_query_t;

    typedef enum int {
        SCENE_ANY,
        SCENE_POINT_WALL,
        SCENE_NO_RADIUS,
        SCENE_LOCAL
    } scene_t;

    typedef enum int {
        RECV_FREE,
        RECV_LIGHT,
        RECV_HEAVY,
        RECV_ALTERNATE
    } recv_mode_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    in_valid = 1'b0;
    logic    in_stall;
    coord_t  wall_x1 = '0;
    coord_t  wall_y1 = '0;
    coord_t  wall_x2 = '0;
    coord_t  wall_y2 = '0;
    coord_t  ball_x = '0;
    coord_t  ball_y = '0;
    radius_t ball_radius = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    logic    hit;

    wall_query_t pending_queries[$];
    bit          expected_hits[$];
    int          total_queries = 0;
    int          accepted_queries = 0;
    int          error_count = 0;

    int          burst_left = 0;
    int          gap_left = 0;
    bit          offer;
    wall_query_t next_query;

    int          cycle_count = 0;
    logic        hold_off = 1'b0;
    recv_mode_t  recv_mode = RECV_FREE;
    bit          expected_hit;
    bit          next_stall;

    circle_segment_collision_test #(
        .COORD_WIDTH(COORD_WIDTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .wall_x1    (wall_x1),
        .wall_y1    (wall_y1),
        .wall_x2    (wall_x2),
        .wall_y2    (wall_y2),
        .ball_x     (ball_x),
        .ball_y     (ball_y),
        .ball_radius(ball_radius),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .hit        (hit)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Exact squared-distance test; 128 bits hold every product without loss.
    function automatic bit circle_touches_wall(input wall_query_t q);
        logic signed [127:0] x1, y1, x2, y2, bx, by;
        logic signed [127:0] rr, d1, d2, cross_prod, len2, dot;
        x1 = $signed(q.wall_x1);
        y1 = $signed(q.wall_y1);
        x2 = $signed(q.wall_x2);
        y2 = $signed(q.wall_y2);
        bx = $signed(q.ball_x);
        by = $signed(q.ball_y);
        rr = q.ball_radius;
        rr = rr * rr;
        d1 = (bx - x1) * (bx - x1) + (by - y1) * (by - y1);
        d2 = (bx - x2) * (bx - x2) + (by - y2) * (by - y2);
        if (d1 < rr || d2 < rr)
            return 1'b1;
        cross_prod = (x1 - bx) * (y2 - by) - (y1 - by) * (x2 - bx);
        len2  = (x2 - x1) * (x2 - x1) + (y2 - y1) * (y2 - y1);
        if (cross_prod * cross_prod >= rr * len2)
            return 1'b0;
        dot = (bx - x1) * (x2 - x1) + (by - y1) * (y2 - y1);
        return (dot >= 0 && dot <= len2);
    endfunction

    task automatic add_query(input int x1, input int y1, input int x2, input int y2,
                             input int bx, input int by, input int r);
        wall_query_t q;
        q.wall_x1     = coord_t'(x1);
        q.wall_y1     = coord_t'(y1);
        q.wall_x2     = coord_t'(x2);
        q.wall_y2     = coord_t'(y2);
        q.ball_x      = coord_t'(bx);
        q.ball_y      = coord_t'(by);
        q.ball_radius = radius_t'(r);
        pending_queries.push_back(q);
        total_queries++;
    endtask

    function automatic int near_value(input int centre, input int span);
        return centre + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Most queries are local scenes where hits and misses are both common.
    task automatic add_random_query();
        scene_t scene;
        int     span, cx, cy, x1, y1, bx, by;
        case ($urandom_range(0, 9))
            0:       scene = SCENE_ANY;
            1:       scene = SCENE_POINT_WALL;
            2:       scene = SCENE_NO_RADIUS;
            default: scene = SCENE_LOCAL;
        endcase
        case ($urandom_range(0, 2))
            0:       span = 64;
            1:       span = 1024;
            default: span = 8000;
        endcase
        cx = near_value(0, 16000);
        cy = near_value(0, 16000);
        x1 = near_value(cx, span);
        y1 = near_value(cy, span);
        bx = near_value(cx, span);
        by = near_value(cy, span);
        case (scene)
            SCENE_ANY:
                add_query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          $urandom);
            SCENE_POINT_WALL:
                add_query(x1, y1, x1, y1, bx, by, $urandom_range(0, 2 * span));
            SCENE_NO_RADIUS:
                add_query(x1, y1, near_value(cx, span), near_value(cy, span), bx, by, 0);
            default:
                add_query(x1, y1, near_value(cx, span), near_value(cy, span), bx, by,
                          $urandom_range(0, span));
        endcase
    endtask

    task automatic note_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("ERROR: %s", msg);
    endtask

    // Sender: bursts of transfers separated by random gaps, gaps dropped during the hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            burst_left = 0;
            gap_left = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_hits.push_back(circle_touches_wall({wall_x1, wall_y1, wall_x2,
                    wall_y2, ball_x, ball_y, ball_radius}));
                accepted_queries++;
            end
            if (!(in_valid && in_stall))
            begin
                offer = 1'b0;
                if (gap_left > 0 && !hold_off)
                    gap_left--;
                else if (pending_queries.size() > 0)
                begin
                    offer = 1'b1;
                    next_query = pending_queries.pop_front();
                    wall_x1     <= next_query.wall_x1;
                    wall_y1     <= next_query.wall_y1;
                    wall_x2     <= next_query.wall_x2;
                    wall_y2     <= next_query.wall_y2;
                    ball_x      <= next_query.ball_x;
                    ball_y      <= next_query.ball_y;
                    ball_radius <= next_query.ball_radius;
                    if (burst_left > 0)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end
                in_valid <= offer;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count <= 0;
            hold_off <= 1'b0;
        end
        else
        begin
            cycle_count <= cycle_count + 1;
            hold_off <= (cycle_count >= 300 && cycle_count < 420);
        end
    end

    // Receiver: checks each transfer, picks a fresh stall pattern periodically and stalls during the hold-off.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_hits.size() == 0)
                    note_error($sformatf("result with nothing expected, hit=%b", hit));
                else
                begin
                    expected_hit = expected_hits.pop_front();
                    if (hit !== expected_hit)
                        note_error($sformatf("hit expected %b actual %b", expected_hit, hit));
                end
            end
            if (cycle_count % 64 == 0)
                recv_mode = recv_mode_t'($urandom_range(0, 3));
            case (recv_mode)
                RECV_FREE:   next_stall = 1'b0;
                RECV_LIGHT:  next_stall = ($urandom_range(0, 3) == 0);
                RECV_HEAVY:  next_stall = ($urandom_range(0, 3) != 0);
                default:     next_stall = cycle_count[0];
            endcase
            out_stall <= next_stall || hold_off;
        end
    end

    initial
    begin
        // Zero radius never hits, even with the centre on an endpoint.
        add_query(0, 0, 100, 0, 0, 0, 0);
        add_query(-100, 0, 100, 0, 0, 0, 0);
        // Degenerate wall: inside, exactly on the circle, outside.
        add_query(50, 50, 50, 50, 40, 40, 20);
        add_query(30, 40, 30, 40, 0, 0, 50);
        add_query(30, 40, 30, 40, 0, 0, 49);
        // Exact tangency misses, one step more hits.
        add_query(-100, 0, 100, 0, 0, 50, 50);
        add_query(-100, 0, 100, 0, 0, 50, 51);
        // Centre projecting onto an endpoint.
        add_query(0, 0, 100, 0, 0, 30, 30);
        add_query(0, 0, 100, 0, 0, 30, 31);
        add_query(0, 0, 100, 0, 100, -30, 31);
        // Close to the line but beyond the end of the segment.
        add_query(0, 0, 100, 0, -30, 5, 20);
        // Crossing the middle with both endpoints far outside.
        add_query(-1000, -1000, 1000, 1000, 10, -10, 100);
        add_query(-1000, -1000, 1000, 1000, 500, -500, 100);
        // Extremes of the coordinate and radius ranges.
        add_query(-32768, -32768, 32767, 32767, 0, 0, 32767);
        add_query(-32768, 32767, 32767, -32768, -32768, -32768, 32767);
        add_query(32767, 32767, 32767, 32767, -32768, -32768, 32767);
        add_query(-32768, -32768, 32767, -32768, 0, 32767, 32767);
        add_query(-32768, -32768, -32768, -32768, -32768, -32768, 0);
        add_query(32767, 32767, 32767, 32767, 32767, 32767, 1);
        add_query(0, 0, 0, 0, 0, 0, 32767);
        add_query(-32768, 32767, -32768, 32767, 32767, -32768, 32767);
        repeat (RANDOM_ITEMS)
            add_random_query();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_queries < total_queries)
            @(posedge clk);
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Regression FAIL");
        $finish;
    end

endmodule
